// ===== hdl/csvtok_pkg.sv =====
// ============================================================================
// CSV tokenizer package
// Shared types, result codes, register indexes and constants of the CSV
// field tokenizer.
// ============================================================================
`default_nettype none

package csvtok_pkg;

    // One input request: a stream byte or the end-of-stream mark.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } in_item_t;

    // One result request.
    typedef struct packed {
        logic [2:0] result_kind;
        logic [7:0] out_byte;
        logic       last_of_run;
    } out_item_t;

    // Configuration registers as seen by the parser.
    typedef struct packed {
        logic [7:0] field_separator;
        logic [7:0] quote_char;
    } cfg_t;

    // Everything one input byte produces: zero, one or two results.
    typedef struct packed {
        logic [1:0] res_count;
        out_item_t  res0;
        out_item_t  res1;
    } parse_out_t;

    // Result kinds.
    localparam logic [2:0] KIND_DATA    = 3'd0;
    localparam logic [2:0] KIND_RESTART = 3'd1;
    localparam logic [2:0] KIND_FIELD   = 3'd2;
    localparam logic [2:0] KIND_ROW     = 3'd3;
    localparam logic [2:0] KIND_STREAM  = 3'd4;

    // Configuration register indexes.
    localparam logic CFG_FIELD_SEPARATOR = 1'b0;
    localparam logic CFG_QUOTE_CHAR      = 1'b1;

    // Reset values and fixed bytes.
    localparam logic [7:0] SEPARATOR_RESET = 8'd44;
    localparam logic [7:0] QUOTE_RESET     = 8'd34;
    localparam logic [7:0] NEWLINE_BYTE    = 8'd10;

    // Number of entries in the result queue.
    localparam int QUEUE_DEPTH = 3;

    // Build a result; the byte is carried only by data results.
    function automatic out_item_t make_result(input logic [2:0] kind,
                                              input logic [7:0] value);
        out_item_t r;
        r.result_kind = kind;
        r.out_byte    = (kind == KIND_DATA) ? value : 8'd0;
        r.last_of_run = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/csvtok_parser.sv =====
// ============================================================================
// CSV tokenizer parser
// Holds the parse mode and decodes one byte into up to two results.
// ============================================================================
`default_nettype none

module csvtok_parser (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    accept,
    input  wire csvtok_pkg::in_item_t    item,
    input  wire csvtok_pkg::cfg_t        cfg,
    output csvtok_pkg::parse_out_t       results
);

    typedef enum logic [2:0] {
        MODE_OUT    = 3'd0,
        MODE_IN     = 3'd1,
        MODE_QSEEN  = 3'd2,
        MODE_SKIP   = 3'd3,
        MODE_NLPEND = 3'd4
    } mode_t;

    mode_t mode_reg;
    mode_t mode_next;

    // Decode of the byte as seen outside quotes and after a closing quote.
    always_comb
    begin
        logic [7:0]  b;
        logic        o_emit;
        logic [2:0]  o_kind;
        mode_t       o_mode;
        logic        t_emit;
        mode_t       t_mode;
        csvtok_pkg::parse_out_t r;

        b = item.data_byte;

        // Outside quotes: quote first, then separator, then newline.
        if (b == cfg.quote_char)
        begin
            o_emit = 1'b1;
            o_kind = csvtok_pkg::KIND_RESTART;
            o_mode = MODE_IN;
        end
        else if (b == cfg.field_separator)
        begin
            o_emit = 1'b1;
            o_kind = csvtok_pkg::KIND_FIELD;
            o_mode = MODE_OUT;
        end
        else if (b == csvtok_pkg::NEWLINE_BYTE)
        begin
            o_emit = 1'b0;
            o_kind = csvtok_pkg::KIND_DATA;
            o_mode = MODE_NLPEND;
        end
        else
        begin
            o_emit = 1'b1;
            o_kind = csvtok_pkg::KIND_DATA;
            o_mode = MODE_OUT;
        end

        // After a closing quote: separator, then newline, else skip.
        if (b == cfg.field_separator)
        begin
            t_emit = 1'b1;
            t_mode = MODE_OUT;
        end
        else if (b == csvtok_pkg::NEWLINE_BYTE)
        begin
            t_emit = 1'b0;
            t_mode = MODE_NLPEND;
        end
        else
        begin
            t_emit = 1'b0;
            t_mode = MODE_SKIP;
        end

        r.res_count = 2'd0;
        r.res0      = csvtok_pkg::make_result(csvtok_pkg::KIND_DATA, b);
        r.res1      = csvtok_pkg::make_result(o_kind, b);
        mode_next   = mode_reg;

        if (item.stream_end)
        begin
            // End of stream closes everything and restarts the mode.
            r.res_count = 2'd1;
            r.res0      = csvtok_pkg::make_result(csvtok_pkg::KIND_STREAM, b);
            mode_next   = MODE_OUT;
        end
        else
        begin
            case (mode_reg)
                MODE_IN:
                begin
                    if (b == cfg.quote_char)
                    begin
                        mode_next = MODE_QSEEN;
                    end
                    else
                    begin
                        r.res_count = 2'd1;
                    end
                end
                MODE_QSEEN:
                begin
                    if (b == cfg.quote_char)
                    begin
                        // A doubled quote gives one data quote.
                        mode_next   = MODE_IN;
                        r.res_count = 2'd1;
                    end
                    else
                    begin
                        mode_next   = t_mode;
                        r.res_count = {1'b0, t_emit};
                        r.res0      = csvtok_pkg::make_result(csvtok_pkg::KIND_FIELD, b);
                    end
                end
                MODE_SKIP:
                begin
                    mode_next   = t_mode;
                    r.res_count = {1'b0, t_emit};
                    r.res0      = csvtok_pkg::make_result(csvtok_pkg::KIND_FIELD, b);
                end
                MODE_NLPEND:
                begin
                    // The row ends, then the byte opens the next row.
                    mode_next   = o_mode;
                    r.res_count = o_emit ? 2'd2 : 2'd1;
                    r.res0      = csvtok_pkg::make_result(csvtok_pkg::KIND_ROW, b);
                end
                default:
                begin
                    mode_next   = o_mode;
                    r.res_count = {1'b0, o_emit};
                    r.res0      = csvtok_pkg::make_result(o_kind, b);
                end
            endcase
        end

        // Mark the final result of this byte.
        if (r.res_count == 2'd1)
        begin
            r.res0.last_of_run = 1'b1;
        end
        if (r.res_count == 2'd2)
        begin
            r.res1.last_of_run = 1'b1;
        end

        results = r;
    end

    // Parse mode register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_OUT;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/csv_field_tokenizer_top.sv =====
// ============================================================================
// CSV field tokenizer
// Splits a CSV byte stream into field characters and field, row and stream
// end markers, with quoted fields and doubled quotes.
// ============================================================================
//
// Channel   Direction  Handshake          Request
// in        input      in_valid/in_stall  in_data: data_byte, stream_end
// out       output     out_valid/out_stall out_data: result_kind, out_byte,
//                                         last_of_run
// cfg       input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// A byte is decoded in the cycle it is accepted; its results are registered
// into a three-entry queue whose head drives out_data.
// One byte per cycle is taken while the queue holds at most one result;
// in_stall is high at two or more, so a row end plus a byte can raise it.
// Reset clears the parse mode and the queue and restores comma and double
// quote as separator and quote; cfg_ready is always high.
`default_nettype none

module csv_field_tokenizer_top (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire csvtok_pkg::in_item_t    in_data,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output csvtok_pkg::out_item_t        out_data,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic                    cfg_index,
    input  wire logic [7:0]              cfg_data
);

    logic [7:0]                  separator_reg;
    logic [7:0]                  quote_reg;
    csvtok_pkg::out_item_t       queue_reg  [csvtok_pkg::QUEUE_DEPTH];
    csvtok_pkg::out_item_t       queue_next [csvtok_pkg::QUEUE_DEPTH];
    logic [1:0]                  fill_reg;
    logic [1:0]                  fill_next;
    logic                        push;
    logic                        pop;
    csvtok_pkg::cfg_t            cfg;
    csvtok_pkg::parse_out_t      results;

    assign cfg_ready = 1'b1;
    assign cfg.field_separator = separator_reg;
    assign cfg.quote_char      = quote_reg;

    // Handshakes.
    assign in_stall  = (fill_reg >= 2'd2);
    assign push      = in_valid && !in_stall;
    assign out_valid = (fill_reg != 2'd0);
    assign pop       = out_valid && !out_stall;
    assign out_data  = queue_reg[0];

    csvtok_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (push),
        .item    (in_data),
        .cfg     (cfg),
        .results (results)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            separator_reg <= csvtok_pkg::SEPARATOR_RESET;
            quote_reg     <= csvtok_pkg::QUOTE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                csvtok_pkg::CFG_FIELD_SEPARATOR: separator_reg <= cfg_data;
                csvtok_pkg::CFG_QUOTE_CHAR:      quote_reg     <= cfg_data;
                default:                         separator_reg <= separator_reg;
            endcase
        end
    end

    // Result queue: shift down on a pop, then append the new results.
    always_comb
    begin
        logic [1:0] base;
        logic [1:0] add;

        base = fill_reg - {1'b0, pop};
        add  = push ? results.res_count : 2'd0;

        for (int i = 0; i < csvtok_pkg::QUEUE_DEPTH; i++)
        begin
            if (pop && (i < csvtok_pkg::QUEUE_DEPTH - 1))
            begin
                queue_next[i] = queue_reg[i + 1];
            end
            else
            begin
                queue_next[i] = queue_reg[i];
            end
            if ((add != 2'd0) && (2'(i) == base))
            begin
                queue_next[i] = results.res0;
            end
            if ((add == 2'd2) && (2'(i) == base + 2'd1))
            begin
                queue_next[i] = results.res1;
            end
        end

        fill_next = base + add;
    end

    // Queue fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= 2'd0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    // Queue payload.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < csvtok_pkg::QUEUE_DEPTH; i++)
        begin
            queue_reg[i] <= queue_next[i];
        end
    end

endmodule

`default_nettype wire
